@@ design/tcal_pkg.sv @@
// ----------------------------------------------------------------------------
// tcal_pkg: shared types and constants of the tariff calendar
// Table sizes, entry layouts, transaction codes, sequencer states and the
// weekday profile picker used by the calendar lookup.
// ----------------------------------------------------------------------------
package tcal_pkg;

  // Table sizes
  localparam int SEASON_SLOTS  = 8;
  localparam int PROFILE_COUNT = 8;
  localparam int WINDOW_SLOTS  = 8;

  // Slots that a 3-bit result index can name
  localparam int FIELD_SLOTS = 8;

  localparam int SEASON_SCAN = (SEASON_SLOTS < FIELD_SLOTS) ? SEASON_SLOTS : FIELD_SLOTS;
  localparam int WINDOW_SCAN = (WINDOW_SLOTS < FIELD_SLOTS) ? WINDOW_SLOTS : FIELD_SLOTS;

  // Index and address widths
  localparam int SIDX_W   = (SEASON_SLOTS > 1) ? $clog2(SEASON_SLOTS) : 1;
  localparam int WSLOT_W  = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1;
  localparam int PROF_W   = (PROFILE_COUNT > 1) ? $clog2(PROFILE_COUNT) : 1;
  localparam int WADDR_W  = PROF_W + WSLOT_W;
  localparam int WIN_DEPTH = 1 << WADDR_W;
  localparam int CCNT_W   = WADDR_W + 1;

  // Field widths
  localparam int DATE_W = 12;
  localparam int TIME_W = 13;
  localparam int WEEK_W = 21;
  localparam int TARIFF_W = 8;

  // Highest weekday that selects a profile
  localparam logic [2:0] WEEKDAY_MAX = 3'd6;

  // Transaction codes carried in the input tuser
  typedef enum logic [1:0] {
    OP_WR_SEASON = 2'd0,
    OP_WR_WINDOW = 2'd1,
    OP_COMMIT    = 2'd2,
    OP_LOOKUP    = 2'd3
  } op_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COPY,
    ST_SEASON,
    ST_WINDOW,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [DATE_W-1:0] begin_date;
    logic [DATE_W-1:0] end_date;
    logic [WEEK_W-1:0] week_profiles;
  } season_entry_t;

  typedef struct packed {
    logic [TIME_W-1:0]   begin_time;
    logic [TIME_W-1:0]   end_time;
    logic [TARIFF_W-1:0] tariff;
  } win_entry_t;

  // Result layout, lowest field in the lowest bits
  typedef struct packed {
    logic [TIME_W-1:0]   window_end;
    logic [TARIFF_W-1:0] tariff_code;
    logic [2:0]          window_index;
    logic                window_found;
    logic [2:0]          day_profile;
    logic [2:0]          season_index;
    logic                season_found;
  } result_t;

  // Pick the 3-bit profile of one weekday; weekday 7 gives zero
  function automatic logic [2:0] week_pick(input logic [WEEK_W-1:0] week,
                                           input logic [2:0] wday);
    logic [2:0] pick;
    pick = 3'd0;
    for (int d = 0; d < 7; d++) begin
      if (wday == 3'(d)) begin
        pick = week[3*d +: 3];
      end
    end
    return pick;
  endfunction

endpackage

@@ design/tcal_ram.sv @@
// ----------------------------------------------------------------------------
// tcal_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module tcal_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/tcal_range_unit.sv @@
// ----------------------------------------------------------------------------
// tcal_range_unit: shared inclusive range compare
// Tells whether a key lies between a low and a high bound, both included.
// Serves the season scan and the window scan in turn.
// ----------------------------------------------------------------------------
module tcal_range_unit (
  input  logic [tcal_pkg::TIME_W-1:0] key,
  input  logic [tcal_pkg::TIME_W-1:0] lo,
  input  logic [tcal_pkg::TIME_W-1:0] hi,
  output logic                        hit
);

  // An inverted range never matches
  assign hit = (key >= lo) && (key <= hi);

endmodule

@@ design/tou_tariff_calendar_lookup.sv @@
// ----------------------------------------------------------------------------
// tou_tariff_calendar_lookup: time-of-use tariff calendar
// Write transactions fill the backup season and window tables; a commit
// copies them into the used tables; a lookup walks the used seasons for the
// date, takes that season's profile for the weekday, then walks the window
// slots of that profile for the time and returns one result. A lookup scans
// up to 8 season slots and up to 8 window slots through the single shared
// range comparator. A commit copies the window RAM one entry per cycle.
// Input is not accepted while a lookup or commit runs; a finished result
// waits in the output register without blocking new input.
// ----------------------------------------------------------------------------
module tou_tariff_calendar_lookup (
  input  logic        clk,
  input  logic        rst_n,
  // Input transactions
  input  logic        in_tvalid,
  output logic        in_tready,
  // [2:0] entry_index, [5:3] profile_select, [17:6] begin_date,
  // [29:18] end_date, [50:30] week_profiles, [53:51] weekday,
  // [66:54] begin_time, [79:67] end_time, [87:80] tariff_in
  input  logic [87:0] in_tdata,
  // [1:0] operation
  input  logic [1:0]  in_tuser,
  // Result transactions
  output logic        out_tvalid,
  input  logic        out_tready,
  // [0] season_found, [3:1] season_index, [6:4] day_profile,
  // [7] window_found, [10:8] window_index, [18:11] tariff_code,
  // [31:19] window_end
  output logic [31:0] out_tdata
);

  localparam int SIDX_W  = tcal_pkg::SIDX_W;
  localparam int WSLOT_W = tcal_pkg::WSLOT_W;
  localparam int PROF_W  = tcal_pkg::PROF_W;
  localparam int WADDR_W = tcal_pkg::WADDR_W;
  localparam int CCNT_W  = tcal_pkg::CCNT_W;
  localparam int TIME_W  = tcal_pkg::TIME_W;

  // Input fields
  logic [2:0]                     in_entry_index;
  logic [2:0]                     in_profile_select;
  logic [tcal_pkg::DATE_W-1:0]    in_begin_date;
  logic [tcal_pkg::DATE_W-1:0]    in_end_date;
  logic [tcal_pkg::WEEK_W-1:0]    in_week_profiles;
  logic [2:0]                     in_weekday;
  logic [TIME_W-1:0]              in_begin_time;
  logic [TIME_W-1:0]              in_end_time;
  logic [tcal_pkg::TARIFF_W-1:0]  in_tariff_in;
  tcal_pkg::op_t                  in_operation;
  logic                           in_fire;

  assign in_entry_index    = in_tdata[2:0];
  assign in_profile_select = in_tdata[5:3];
  assign in_begin_date     = in_tdata[17:6];
  assign in_end_date       = in_tdata[29:18];
  assign in_week_profiles  = in_tdata[50:30];
  assign in_weekday        = in_tdata[53:51];
  assign in_begin_time     = in_tdata[66:54];
  assign in_end_time       = in_tdata[79:67];
  assign in_tariff_in      = in_tdata[87:80];
  assign in_operation      = tcal_pkg::op_t'(in_tuser);
  assign in_fire           = in_tvalid && in_tready;

  // State
  tcal_pkg::state_t state_r, state_nxt;

  tcal_pkg::season_entry_t bseason_r [tcal_pkg::SEASON_SLOTS];
  tcal_pkg::season_entry_t useason_r [tcal_pkg::SEASON_SLOTS];
  logic [tcal_pkg::SEASON_SLOTS-1:0] bsvalid_r, bsvalid_nxt;
  logic [tcal_pkg::SEASON_SLOTS-1:0] usvalid_r, usvalid_nxt;
  logic [tcal_pkg::WIN_DEPTH-1:0]    bwvalid_r, bwvalid_nxt;
  logic [tcal_pkg::WIN_DEPTH-1:0]    uwvalid_r, uwvalid_nxt;

  logic [SIDX_W-1:0]           scnt_r, scnt_nxt;
  logic [WSLOT_W-1:0]          wcnt_r, wcnt_nxt;
  logic [2:0]                  prof_r, prof_nxt;
  logic [CCNT_W-1:0]           ccnt_r, ccnt_nxt;
  logic                        cwr_r, cwr_nxt;
  logic [WADDR_W-1:0]          caddr_r, caddr_nxt;
  logic [tcal_pkg::DATE_W-1:0] lk_date_r, lk_date_nxt;
  logic [TIME_W-1:0]           lk_time_r, lk_time_nxt;
  logic [2:0]                  lk_wday_r, lk_wday_nxt;
  tcal_pkg::result_t           res_r, res_nxt;
  tcal_pkg::result_t           out_res_r, out_res_nxt;
  logic                        out_valid_r, out_valid_nxt;

  // Season write decode
  logic               sw_en;
  logic [SIDX_W-1:0]  sw_idx;
  // Window addresses
  logic [WADDR_W-1:0] bw_waddr;
  logic               bw_we;
  logic [WADDR_W-1:0] bw_raddr;
  logic [WADDR_W-1:0] uw_raddr;
  logic [WADDR_W-1:0] uw_cmp_addr;
  tcal_pkg::win_entry_t bw_wdata, bw_rdata, uw_rdata;

  // Scan datapath
  tcal_pkg::season_entry_t cur_season;
  logic [2:0]         scan_prof;
  logic               prof_ok;
  logic               season_last, window_last;
  logic               copy_issue;
  logic               result_load;
  logic [TIME_W-1:0]  cmp_key, cmp_lo, cmp_hi;
  logic               cmp_hit;
  logic               season_hit, window_hit;

  assign sw_idx  = SIDX_W'(in_entry_index);
  assign sw_en   = in_fire && (in_operation == tcal_pkg::OP_WR_SEASON) &&
                   (32'(in_entry_index) < tcal_pkg::SEASON_SLOTS);
  assign bw_we   = in_fire && (in_operation == tcal_pkg::OP_WR_WINDOW) &&
                   (32'(in_entry_index) < tcal_pkg::WINDOW_SLOTS) &&
                   (32'(in_profile_select) < tcal_pkg::PROFILE_COUNT);
  assign bw_waddr = {PROF_W'(in_profile_select), WSLOT_W'(in_entry_index)};
  assign bw_wdata = '{begin_time: in_begin_time, end_time: in_end_time,
                      tariff: in_tariff_in};
  assign bw_raddr = ccnt_r[WADDR_W-1:0];

  assign cur_season  = useason_r[scnt_r];
  assign scan_prof   = tcal_pkg::week_pick(cur_season.week_profiles, lk_wday_r);
  assign prof_ok     = (lk_wday_r <= tcal_pkg::WEEKDAY_MAX) &&
                       (32'(scan_prof) < tcal_pkg::PROFILE_COUNT);
  assign season_last = (scnt_r == SIDX_W'(tcal_pkg::SEASON_SCAN - 1));
  assign window_last = (wcnt_r == WSLOT_W'(tcal_pkg::WINDOW_SCAN - 1));
  assign uw_cmp_addr = {PROF_W'(prof_r), wcnt_r};
  assign copy_issue  = (ccnt_r != CCNT_W'(tcal_pkg::WIN_DEPTH));
  assign result_load = (state_r == tcal_pkg::ST_DONE) && (!out_valid_r || out_tready);

  // Share one range compare between the season and window scans
  always_comb begin
    if (state_r == tcal_pkg::ST_WINDOW) begin
      cmp_key = lk_time_r;
      cmp_lo  = uw_rdata.begin_time;
      cmp_hi  = uw_rdata.end_time;
    end else begin
      cmp_key = TIME_W'(lk_date_r);
      cmp_lo  = TIME_W'(cur_season.begin_date);
      cmp_hi  = TIME_W'(cur_season.end_date);
    end
  end

  tcal_range_unit u_range (
    .key (cmp_key),
    .lo  (cmp_lo),
    .hi  (cmp_hi),
    .hit (cmp_hit)
  );

  assign season_hit = cmp_hit && usvalid_r[scnt_r];
  assign window_hit = cmp_hit && uwvalid_r[uw_cmp_addr];

  // Window tables
  tcal_ram #(
    .WIDTH ($bits(tcal_pkg::win_entry_t)),
    .DEPTH (tcal_pkg::WIN_DEPTH)
  ) u_backup_win (
    .clk   (clk),
    .we    (bw_we),
    .waddr (bw_waddr),
    .wdata (bw_wdata),
    .raddr (bw_raddr),
    .rdata (bw_rdata)
  );

  tcal_ram #(
    .WIDTH ($bits(tcal_pkg::win_entry_t)),
    .DEPTH (tcal_pkg::WIN_DEPTH)
  ) u_used_win (
    .clk   (clk),
    .we    (cwr_r),
    .waddr (caddr_r),
    .wdata (bw_rdata),
    .raddr (uw_raddr),
    .rdata (uw_rdata)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tcal_pkg::ST_IDLE: begin
        if (in_fire && in_operation == tcal_pkg::OP_COMMIT) begin
          state_nxt = tcal_pkg::ST_COPY;
        end else if (in_fire && in_operation == tcal_pkg::OP_LOOKUP) begin
          state_nxt = tcal_pkg::ST_SEASON;
        end
      end
      tcal_pkg::ST_COPY: begin
        if (!copy_issue) begin
          state_nxt = tcal_pkg::ST_IDLE;
        end
      end
      tcal_pkg::ST_SEASON: begin
        if (season_hit) begin
          state_nxt = prof_ok ? tcal_pkg::ST_WINDOW : tcal_pkg::ST_DONE;
        end else if (season_last) begin
          state_nxt = tcal_pkg::ST_DONE;
        end
      end
      tcal_pkg::ST_WINDOW: begin
        if (window_hit || window_last) begin
          state_nxt = tcal_pkg::ST_DONE;
        end
      end
      tcal_pkg::ST_DONE: begin
        if (result_load) begin
          state_nxt = tcal_pkg::ST_IDLE;
        end
      end
      default: state_nxt = tcal_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    in_tready = 1'b0;
    uw_raddr  = {PROF_W'(prof_r), WSLOT_W'(wcnt_r + 1'b1)};
    case (state_r)
      tcal_pkg::ST_IDLE:   in_tready = 1'b1;
      tcal_pkg::ST_SEASON: uw_raddr  = {PROF_W'(scan_prof), WSLOT_W'(0)};
      default: ;
    endcase
  end

  // Datapath next values
  always_comb begin
    bsvalid_nxt   = bsvalid_r;
    usvalid_nxt   = usvalid_r;
    bwvalid_nxt   = bwvalid_r;
    uwvalid_nxt   = uwvalid_r;
    scnt_nxt      = scnt_r;
    wcnt_nxt      = wcnt_r;
    prof_nxt      = prof_r;
    ccnt_nxt      = ccnt_r;
    cwr_nxt       = 1'b0;
    caddr_nxt     = caddr_r;
    lk_date_nxt   = lk_date_r;
    lk_time_nxt   = lk_time_r;
    lk_wday_nxt   = lk_wday_r;
    res_nxt       = res_r;
    out_res_nxt   = out_res_r;
    out_valid_nxt = out_valid_r;

    // Mark written slots
    if (sw_en) begin
      bsvalid_nxt[sw_idx] = 1'b1;
    end
    if (bw_we) begin
      bwvalid_nxt[bw_waddr] = 1'b1;
    end

    // Start commit or lookup
    if (in_fire && in_operation == tcal_pkg::OP_COMMIT) begin
      usvalid_nxt = bsvalid_r;
      uwvalid_nxt = bwvalid_r;
      ccnt_nxt    = '0;
    end
    if (in_fire && in_operation == tcal_pkg::OP_LOOKUP) begin
      lk_date_nxt = in_begin_date;
      lk_time_nxt = in_begin_time;
      lk_wday_nxt = in_weekday;
      scnt_nxt    = '0;
      res_nxt     = '0;
    end

    // Copy window RAM one entry per cycle
    if (state_r == tcal_pkg::ST_COPY && copy_issue) begin
      cwr_nxt   = 1'b1;
      caddr_nxt = ccnt_r[WADDR_W-1:0];
      ccnt_nxt  = ccnt_r + 1'b1;
    end

    // Walk season slots
    if (state_r == tcal_pkg::ST_SEASON) begin
      if (season_hit) begin
        res_nxt.season_found = 1'b1;
        res_nxt.season_index = 3'(scnt_r);
        if (lk_wday_r <= tcal_pkg::WEEKDAY_MAX) begin
          res_nxt.day_profile = scan_prof;
        end
        prof_nxt = scan_prof;
        wcnt_nxt = '0;
      end else if (!season_last) begin
        scnt_nxt = scnt_r + 1'b1;
      end
    end

    // Walk window slots of the chosen profile
    if (state_r == tcal_pkg::ST_WINDOW) begin
      if (window_hit) begin
        res_nxt.window_found = 1'b1;
        res_nxt.window_index = 3'(wcnt_r);
        res_nxt.tariff_code  = uw_rdata.tariff;
        res_nxt.window_end   = uw_rdata.end_time;
      end else if (!window_last) begin
        wcnt_nxt = wcnt_r + 1'b1;
      end
    end

    // Output register
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (result_load) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = res_r;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tcal_pkg::ST_IDLE;
      bsvalid_r   <= '0;
      usvalid_r   <= '0;
      bwvalid_r   <= '0;
      uwvalid_r   <= '0;
      cwr_r       <= 1'b0;
      out_valid_r <= 1'b0;
      ccnt_r      <= '0;
      scnt_r      <= '0;
      wcnt_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      bsvalid_r   <= bsvalid_nxt;
      usvalid_r   <= usvalid_nxt;
      bwvalid_r   <= bwvalid_nxt;
      uwvalid_r   <= uwvalid_nxt;
      cwr_r       <= cwr_nxt;
      out_valid_r <= out_valid_nxt;
      ccnt_r      <= ccnt_nxt;
      scnt_r      <= scnt_nxt;
      wcnt_r      <= wcnt_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    prof_r    <= prof_nxt;
    caddr_r   <= caddr_nxt;
    lk_date_r <= lk_date_nxt;
    lk_time_r <= lk_time_nxt;
    lk_wday_r <= lk_wday_nxt;
    res_r     <= res_nxt;
    out_res_r <= out_res_nxt;
  end

  // Season tables: write backup, copy to used on commit
  always_ff @(posedge clk) begin
    if (sw_en) begin
      bseason_r[sw_idx] <= '{begin_date: in_begin_date, end_date: in_end_date,
                             week_profiles: in_week_profiles};
    end
    if (in_fire && in_operation == tcal_pkg::OP_COMMIT) begin
      useason_r <= bseason_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_res_r;

endmodule

@@ sim/tb_tou_tariff_calendar_lookup.sv @@
// ----------------------------------------------------------------------------
// tb_tou_tariff_calendar_lookup: stream-level test of the tariff calendar
// A queue of season writes, window writes, commits and lookups is built up
// front and fed through the input stream with random gaps. A predictor keeps
// its own backup and live copies of the calendar and computes the expected
// result of each accepted lookup. Each result that leaves the block
// is checked field by field against the oldest expected one. The result side
// is stalled at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_tou_tariff_calendar_lookup;

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int TARGET_ITEMS  = 1300;
  localparam int MAX_PAUSE     = 18;
  localparam int SETTLE_CYCLES = 100;

  localparam int DATE_W        = tcal_pkg::DATE_W;
  localparam int TIME_W        = tcal_pkg::TIME_W;
  localparam int WEEK_W        = tcal_pkg::WEEK_W;
  localparam int TARIFF_W      = tcal_pkg::TARIFF_W;
  localparam int SEASON_SLOTS  = tcal_pkg::SEASON_SLOTS;
  localparam int PROFILE_COUNT = tcal_pkg::PROFILE_COUNT;
  localparam int WINDOW_SLOTS  = tcal_pkg::WINDOW_SLOTS;
  localparam int SEASON_SCAN   = tcal_pkg::SEASON_SCAN;
  localparam int WINDOW_SCAN   = tcal_pkg::WINDOW_SCAN;
  localparam logic [2:0] WEEKDAY_MAX = tcal_pkg::WEEKDAY_MAX;

  typedef struct packed {
    tcal_pkg::op_t       op;
    logic [2:0]          entry_index;
    logic [2:0]          profile_select;
    logic [DATE_W-1:0]   begin_date;
    logic [DATE_W-1:0]   end_date;
    logic [WEEK_W-1:0]   week_profiles;
    logic [2:0]          weekday;
    logic [TIME_W-1:0]   begin_time;
    logic [TIME_W-1:0]   end_time;
    logic [TARIFF_W-1:0] tariff_in;
    bit                  drain;       // hold this transaction until no result is due
  } cal_item_t;

  typedef struct packed {
    bit                valid;
    logic [DATE_W-1:0] first_date;
    logic [DATE_W-1:0] last_date;
    logic [WEEK_W-1:0] week_profiles;
  } season_rec_t;

  typedef struct packed {
    bit                  valid;
    logic [TIME_W-1:0]   first_time;
    logic [TIME_W-1:0]   last_time;
    logic [TARIFF_W-1:0] tariff;
  } window_rec_t;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [87:0] in_tdata   = '0;
  logic [1:0]  in_tuser   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;

  // Predictor copy of the calendar
  season_rec_t shadow_seasons [SEASON_SLOTS];
  season_rec_t live_seasons   [SEASON_SLOTS];
  window_rec_t shadow_windows [PROFILE_COUNT][WINDOW_SLOTS];
  window_rec_t live_windows   [PROFILE_COUNT][WINDOW_SLOTS];

  cal_item_t         pending_items[$];
  tcal_pkg::result_t lookup_results[$];
  cal_item_t         cur_item;

  logic in_accepted  = 1'b0;
  logic out_accepted = 1'b0;
  int   item_total   = 0;
  int   error_count  = 0;
  int   cycle_count  = 0;
  int   send_wait    = 0;
  bit   send_burst   = 1'b0;
  int   recv_wait    = 0;
  bit   recv_burst   = 1'b0;
  bit   recv_armed   = 1'b0;

  tou_tariff_calendar_lookup dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    error_count++;
    $display("cycle %0d: %s: got %0h, expected %0h", cycle_count, what, got, want);
  endtask

  // Walk the live seasons for the date, then the windows of the chosen profile
  function automatic tcal_pkg::result_t tariff_lookup(input cal_item_t it);
    tcal_pkg::result_t r;
    int      s_hit;
    int      w_hit;
    int      prof;
    r     = '0;
    s_hit = -1;
    w_hit = -1;
    for (int i = 0; i < SEASON_SCAN; i++) begin
      if (s_hit < 0 && live_seasons[i].valid &&
          it.begin_date >= live_seasons[i].first_date &&
          it.begin_date <= live_seasons[i].last_date) begin
        s_hit = i;
      end
    end
    if (s_hit < 0) return r;
    r.season_found = 1'b1;
    r.season_index = 3'(s_hit);
    if (it.weekday > WEEKDAY_MAX) return r;
    prof = int'((live_seasons[s_hit].week_profiles >> (3 * int'(it.weekday))) & 'h7);
    r.day_profile = 3'(prof);
    if (prof >= PROFILE_COUNT) return r;
    for (int i = 0; i < WINDOW_SCAN; i++) begin
      if (w_hit < 0 && live_windows[prof][i].valid &&
          it.begin_time >= live_windows[prof][i].first_time &&
          it.begin_time <= live_windows[prof][i].last_time) begin
        w_hit = i;
      end
    end
    if (w_hit < 0) return r;
    r.window_found = 1'b1;
    r.window_index = 3'(w_hit);
    r.tariff_code  = live_windows[prof][w_hit].tariff;
    r.window_end   = live_windows[prof][w_hit].last_time;
    return r;
  endfunction

  // Update the calendar copy, or predict a lookup, for one accepted transaction
  task automatic calendar_apply(input cal_item_t it);
    case (it.op)
      tcal_pkg::OP_WR_SEASON: begin
        if (int'(it.entry_index) < SEASON_SLOTS) begin
          shadow_seasons[it.entry_index] =
            '{1'b1, it.begin_date, it.end_date, it.week_profiles};
        end
      end
      tcal_pkg::OP_WR_WINDOW: begin
        if (int'(it.entry_index) < WINDOW_SLOTS &&
            int'(it.profile_select) < PROFILE_COUNT) begin
          shadow_windows[it.profile_select][it.entry_index] =
            '{1'b1, it.begin_time, it.end_time, it.tariff_in};
        end
      end
      tcal_pkg::OP_COMMIT: begin
        live_seasons = shadow_seasons;
        live_windows = shadow_windows;
      end
      default: begin
        lookup_results.push_back(tariff_lookup(it));
      end
    endcase
  endtask

  task automatic check_result(input tcal_pkg::result_t got);
    tcal_pkg::result_t want;
    if (lookup_results.size() == 0) begin
      report_mismatch("result with no lookup pending", got, '0);
      return;
    end
    want = lookup_results.pop_front();
    if (got.season_found !== want.season_found)
      report_mismatch("season_found", got.season_found, want.season_found);
    if (got.season_index !== want.season_index)
      report_mismatch("season_index", got.season_index, want.season_index);
    if (got.day_profile !== want.day_profile)
      report_mismatch("day_profile", got.day_profile, want.day_profile);
    if (got.window_found !== want.window_found)
      report_mismatch("window_found", got.window_found, want.window_found);
    if (got.window_index !== want.window_index)
      report_mismatch("window_index", got.window_index, want.window_index);
    if (got.tariff_code !== want.tariff_code)
      report_mismatch("tariff_code", got.tariff_code, want.tariff_code);
    if (got.window_end !== want.window_end)
      report_mismatch("window_end", got.window_end, want.window_end);
  endtask

  // Stimulus helpers: unused fields carry random bits
  function automatic cal_item_t noise_item(input tcal_pkg::op_t op);
    cal_item_t it;
    it.op             = op;
    it.entry_index    = 3'($urandom);
    it.profile_select = 3'($urandom);
    it.begin_date     = DATE_W'($urandom);
    it.end_date       = DATE_W'($urandom);
    it.week_profiles  = WEEK_W'($urandom);
    it.weekday        = 3'($urandom);
    it.begin_time     = TIME_W'($urandom);
    it.end_time       = TIME_W'($urandom);
    it.tariff_in      = TARIFF_W'($urandom);
    it.drain          = 1'b0;
    return it;
  endfunction

  function automatic logic [DATE_W-1:0] pick_date();
    if ($urandom_range(0, 7) == 0) return DATE_W'($urandom);
    return DATE_W'(($urandom_range(1, 12) << 8) | $urandom_range(1, 31));
  endfunction

  function automatic logic [TIME_W-1:0] pick_clock();
    if ($urandom_range(0, 7) == 0) return TIME_W'($urandom);
    return TIME_W'(($urandom_range(0, 23) << 8) | $urandom_range(0, 59));
  endfunction

  // Aim at the edges of a range, just outside it, or somewhere inside
  function automatic int near_span(input int lo, input int hi);
    case ($urandom_range(0, 5))
      0:       return lo;
      1:       return hi;
      2:       return lo - 1;
      3:       return hi + 1;
      default: return (lo <= hi) ? int'($urandom_range(lo, hi)) : lo;
    endcase
  endfunction

  task automatic push_item(input cal_item_t it);
    pending_items.push_back(it);
    item_total++;
  endtask

  task automatic add_season(input logic [2:0] slot, input logic [DATE_W-1:0] first,
                            input logic [DATE_W-1:0] last,
                            input logic [WEEK_W-1:0] week);
    cal_item_t it;
    it = noise_item(tcal_pkg::OP_WR_SEASON);
    it.entry_index   = slot;
    it.begin_date    = first;
    it.end_date      = last;
    it.week_profiles = week;
    push_item(it);
  endtask

  task automatic add_window(input logic [2:0] prof, input logic [2:0] slot,
                            input logic [TIME_W-1:0] first,
                            input logic [TIME_W-1:0] last,
                            input logic [TARIFF_W-1:0] tariff);
    cal_item_t it;
    it = noise_item(tcal_pkg::OP_WR_WINDOW);
    it.profile_select = prof;
    it.entry_index    = slot;
    it.begin_time     = first;
    it.end_time       = last;
    it.tariff_in      = tariff;
    push_item(it);
  endtask

  task automatic add_commit(input bit drain);
    cal_item_t it;
    it = noise_item(tcal_pkg::OP_COMMIT);
    it.drain = drain;
    push_item(it);
  endtask

  task automatic add_lookup(input logic [DATE_W-1:0] date, input logic [2:0] wday,
                            input logic [TIME_W-1:0] clock);
    cal_item_t it;
    it = noise_item(tcal_pkg::OP_LOOKUP);
    it.begin_date = date;
    it.weekday    = wday;
    it.begin_time = clock;
    push_item(it);
  endtask

  // Input driver: present one transaction at a time, with a random gap after
  always @(negedge clk) begin : feed
    cal_item_t it;
    if (rst_n && (!in_tvalid || in_accepted)) begin
      if (send_wait > 0) begin
        send_wait--;
        in_tvalid <= 1'b0;
      end else if (pending_items.size() > 0 &&
                   !(pending_items[0].drain && lookup_results.size() > 0)) begin
        it = pending_items.pop_front();
        cur_item  <= it;
        in_tuser  <= it.op;
        in_tdata  <= {it.tariff_in, it.end_time, it.begin_time, it.weekday,
                      it.week_profiles, it.end_date, it.begin_date,
                      it.profile_select, it.entry_index};
        in_tvalid <= 1'b1;
        if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
        send_wait = send_burst ? 0 : $urandom_range(0, MAX_PAUSE);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Result side: stall a random number of cycles once a result shows up
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_accepted) recv_armed = 1'b0;
      if (out_tvalid && !recv_armed) begin
        recv_armed = 1'b1;
        if ($urandom_range(0, 39) == 0) recv_burst = !recv_burst;
        recv_wait = recv_burst ? 0 : $urandom_range(0, MAX_PAUSE);
      end
      if (recv_wait > 0) begin
        recv_wait--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Monitor: predict on each input transaction, check each result transaction
  always @(posedge clk) begin
    if (rst_n) begin
      cycle_count  <= cycle_count + 1;
      in_accepted  <= in_tvalid && in_tready;
      out_accepted <= out_tvalid && out_tready;
      if (in_tvalid && in_tready) calendar_apply(cur_item);
      if (out_tvalid && out_tready) check_result(tcal_pkg::result_t'(out_tdata));
    end
  end

  always @(posedge clk) begin
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    logic [2*DATE_W-1:0] date_spans[$];
    logic [2*TIME_W-1:0] time_spans[$];
    logic [2*DATE_W-1:0] dspan;
    logic [2*TIME_W-1:0] tspan;
    logic [DATE_W-1:0]   d0;
    logic [DATE_W-1:0]   d1;
    logic [TIME_W-1:0]   t0;
    logic [TIME_W-1:0]   t1;
    logic [WEEK_W-1:0]   week;
    logic [2:0]          wday;
    bit                  flip;
    int                  base;
    int                  n;

    for (int i = 0; i < SEASON_SLOTS; i++) begin
      shadow_seasons[i] = '0;
      live_seasons[i]   = '0;
    end
    for (int p = 0; p < PROFILE_COUNT; p++) begin
      for (int i = 0; i < WINDOW_SLOTS; i++) begin
        shadow_windows[p][i] = '0;
        live_windows[p][i]   = '0;
      end
    end

    // Directed: empty calendar, extremes, inverted ranges, stale live tables
    add_lookup(12'h000, 3'd0, 13'h0000);
    add_season(3'd0, 12'h10F, 12'h30A, {3'd6, 3'd5, 3'd4, 3'd3, 3'd2, 3'd1, 3'd0});
    add_season(3'd7, 12'h000, 12'hFFF, 21'h1FFFFF);
    add_season(3'd1, 12'h500, 12'h400, 21'h000000);
    add_window(3'd2, 3'd0, 13'h0800, 13'h0C00, 8'hFF);
    add_window(3'd2, 3'd7, 13'h0000, 13'h1FFF, 8'h00);
    add_window(3'd2, 3'd1, 13'h0900, 13'h0800, 8'h11);
    add_window(3'd7, 3'd3, 13'h0000, 13'h1FFF, 8'h80);
    add_lookup(12'h200, 3'd2, 13'h0900);
    add_commit(1'b1);
    add_lookup(12'h200, 3'd2, 13'h0900);
    add_lookup(12'h10F, 3'd2, 13'h0C00);
    add_lookup(12'h30A, 3'd2, 13'h0C01);
    add_lookup(12'h10F, 3'd7, 13'h0900);
    add_lookup(12'h30A, 3'd3, 13'h0100);
    add_lookup(12'hFFF, 3'd6, 13'h1FFF);
    add_lookup(12'h450, 3'd0, 13'h0000);
    add_lookup(12'h10E, 3'd1, 13'h0C00);
    add_season(3'd0, 12'h600, 12'h6FF, 21'h000000);
    add_lookup(12'h200, 3'd2, 13'h0900);
    add_commit(1'b0);
    add_lookup(12'h200, 3'd2, 13'h0900);
    add_lookup(12'h650, 3'd5, 13'h0900);

    // Random sessions: fill seasons and windows, mostly commit, then aimed lookups
    while (item_total < TARGET_ITEMS) begin
      date_spans.delete();
      time_spans.delete();
      base = $urandom_range(0, 7);
      n = $urandom_range(1, 4);
      for (int k = 0; k < n; k++) begin
        d0 = pick_date();
        d1 = pick_date();
        flip = ($urandom_range(0, 9) == 0);
        if ((d0 > d1) != flip) {d0, d1} = {d1, d0};
        if ($urandom_range(0, 5) == 0) begin
          week = WEEK_W'($urandom);
        end else begin
          for (int j = 0; j < 7; j++) week[3*j +: 3] = 3'(base + $urandom_range(0, 2));
        end
        add_season(3'($urandom), d0, d1, week);
        date_spans.push_back({d0, d1});
      end
      n = $urandom_range(2, 12);
      for (int k = 0; k < n; k++) begin
        t0 = pick_clock();
        t1 = pick_clock();
        flip = ($urandom_range(0, 9) == 0);
        if ((t0 > t1) != flip) {t0, t1} = {t1, t0};
        add_window(3'(base + $urandom_range(0, 2)), 3'($urandom), t0, t1,
                   TARIFF_W'($urandom));
        time_spans.push_back({t0, t1});
      end
      if ($urandom_range(0, 2) == 0) begin
        push_item(noise_item(tcal_pkg::op_t'($urandom_range(0, 3))));
      end
      if ($urandom_range(0, 7) != 0) add_commit($urandom_range(0, 3) == 0);
      n = $urandom_range(4, 30);
      for (int k = 0; k < n; k++) begin
        if ($urandom_range(0, 9) < 7) begin
          dspan = date_spans[$urandom_range(0, date_spans.size() - 1)];
          d0 = DATE_W'(near_span(int'(dspan[2*DATE_W-1:DATE_W]), int'(dspan[DATE_W-1:0])));
        end else begin
          d0 = pick_date();
        end
        if ($urandom_range(0, 9) < 7) begin
          tspan = time_spans[$urandom_range(0, time_spans.size() - 1)];
          t0 = TIME_W'(near_span(int'(tspan[2*TIME_W-1:TIME_W]), int'(tspan[TIME_W-1:0])));
        end else begin
          t0 = pick_clock();
        end
        wday = ($urandom_range(0, 11) == 0) ? 3'd7 : 3'($urandom_range(0, 6));
        add_lookup(d0, wday, t0);
        // Occasional stray write or commit between lookups
        if ($urandom_range(0, 19) == 0) begin
          push_item(noise_item(tcal_pkg::op_t'($urandom_range(0, 2))));
        end
      end
    end

    // Hold reset, then release it and let the driver run
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    while (pending_items.size() > 0 || in_tvalid || lookup_results.size() > 0) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (lookup_results.size() > 0) begin
      report_mismatch("lookups left without result", lookup_results.size(), '0);
    end
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
